[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is applied.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// Implication check, disabled while reset is applied.
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    `ASSERT_CLK(label, clk_sig, rst_sig, (ante) |-> (cons), msg)

`endif

[rtl/jsu_pkg.sv]
// Package for the JSON string unescape core: phase codes, status codes,
// character constants and the hex digit decode. No dependencies.
package jsu_pkg;

    // Decoder phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_STR  = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_NO_OPEN = 3'd2;
    localparam logic [2:0] ST_END_ESC = 3'd3;
    localparam logic [2:0] ST_BAD_HEX = 3'd4;
    localparam logic [2:0] ST_BAD_ESC = 3'd5;
    localparam logic [2:0] ST_UNTERM  = 3'd6;

    // Characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_LF   = 8'h0A;
    localparam logic [7:0] CTL_CR   = 8'h0D;
    localparam logic [7:0] CTL_TAB  = 8'h09;

    localparam logic [15:0] ASCII_MAX   = 16'h007F;
    localparam logic [7:0]  REPL_RESET  = 8'h3F;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r.value = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66)
            r.value = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46)
            r.value = 4'(b - 8'h37);
        else
            r.ok = 1'b0;
        return r;
    endfunction

endpackage

[rtl/json_string_unescape_core.sv]
// JSON string literal unescaper: input register, decode logic, result register.
// Depends on jsu_pkg and assert_macros.svh.
//
//  channel | dir | handshake               | payload
//  s       | in  | s_tvalid / s_tready     | s_tdata: in_byte, s_tuser: at_end
//  m       | out | m_tvalid / m_tready     | m_tdata: out_byte, m_tuser: status
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_data: replacement_char
//
// One item per cycle sustained while the result side is not stalled; a result
// passes through the input register, then the result register.
// An item in the input register waits only when it has a result and the
// result register is full and stalled; items without a result never wait.
// Reset returns the decoder to idle and replacement_char to '?'.
// cfg_ready is always high.
`include "assert_macros.svh"

module json_string_unescape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] at_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [2:0] status
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // [7:0] replacement_char
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  repl_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [2:0]  out_status_reg;

    logic        res_valid;
    logic [7:0]  res_byte;
    logic [2:0]  res_status;
    logic        out_free;
    logic        advance;
    jsu_pkg::hex_digit_t hd;
    logic [15:0] acc_shift;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!res_valid || out_free);
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

    assign hd        = jsu_pkg::hex_decode(in_byte_reg);
    assign acc_shift = {acc_reg[11:0], hd.value};

    // Decode of the item held in the input register
    always_comb
    begin
        res_valid    = 1'b0;
        res_byte     = 8'h00;
        res_status   = jsu_pkg::ST_BYTE;
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        unique case (phase_reg)
            jsu_pkg::PH_STR:
            begin
                if (in_end_reg)
                begin
                    res_valid  = 1'b1;
                    res_status = jsu_pkg::ST_UNTERM;
                    phase_next = jsu_pkg::PH_IDLE;
                end
                else if (in_byte_reg == jsu_pkg::CH_QUOTE)
                begin
                    res_valid  = 1'b1;
                    res_status = jsu_pkg::ST_CLOSED;
                    phase_next = jsu_pkg::PH_IDLE;
                end
                else if (in_byte_reg == jsu_pkg::CH_BSL)
                begin
                    phase_next = jsu_pkg::PH_ESC;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_byte  = in_byte_reg;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                res_valid  = 1'b1;
                phase_next = jsu_pkg::PH_STR;
                if (in_end_reg)
                begin
                    res_status = jsu_pkg::ST_END_ESC;
                    phase_next = jsu_pkg::PH_IDLE;
                end
                else
                begin
                    unique case (in_byte_reg)
                        jsu_pkg::CH_QUOTE: res_byte = jsu_pkg::CH_QUOTE;
                        jsu_pkg::CH_BSL:   res_byte = jsu_pkg::CH_BSL;
                        jsu_pkg::CH_SLASH: res_byte = jsu_pkg::CH_SLASH;
                        jsu_pkg::CH_B:     res_byte = jsu_pkg::CTL_BS;
                        jsu_pkg::CH_F:     res_byte = jsu_pkg::CTL_FF;
                        jsu_pkg::CH_N:     res_byte = jsu_pkg::CTL_LF;
                        jsu_pkg::CH_R:     res_byte = jsu_pkg::CTL_CR;
                        jsu_pkg::CH_T:     res_byte = jsu_pkg::CTL_TAB;
                        jsu_pkg::CH_U:
                        begin
                            res_valid    = 1'b0;
                            phase_next   = jsu_pkg::PH_HEX;
                            hex_cnt_next = 2'd0;
                            acc_next     = 16'h0000;
                        end
                        default:
                        begin
                            res_status = jsu_pkg::ST_BAD_ESC;
                            phase_next = jsu_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (in_end_reg || !hd.ok)
                begin
                    res_valid    = 1'b1;
                    res_status   = jsu_pkg::ST_BAD_HEX;
                    phase_next   = jsu_pkg::PH_IDLE;
                    hex_cnt_next = 2'd0;
                    acc_next     = 16'h0000;
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    acc_next     = acc_shift;
                end
                else
                begin
                    // fourth digit: emit the code or the replacement byte
                    res_valid    = 1'b1;
                    res_byte     = (acc_shift <= jsu_pkg::ASCII_MAX) ? acc_shift[7:0]
                                                                     : repl_reg;
                    phase_next   = jsu_pkg::PH_STR;
                    hex_cnt_next = 2'd0;
                    acc_next     = 16'h0000;
                end
            end
            jsu_pkg::PH_IDLE:
            begin
                if (!in_end_reg)
                begin
                    if (in_byte_reg == jsu_pkg::CH_QUOTE)
                    begin
                        phase_next = jsu_pkg::PH_STR;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_status = jsu_pkg::ST_NO_OPEN;
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= jsu_pkg::PH_IDLE;
            hex_cnt_reg   <= 2'd0;
            acc_reg       <= 16'h0000;
            repl_reg      <= jsu_pkg::REPL_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                phase_reg   <= phase_next;
                hex_cnt_reg <= hex_cnt_next;
                acc_reg     <= acc_next;
            end
            if (advance && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                repl_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser[0];
        end
        if (advance && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
        end
    end

    // Checks
    `ASSERT_IMPL(a_cnt_only_in_hex, clk, rst_n, hex_cnt_reg != 2'd0,
        phase_reg == jsu_pkg::PH_HEX, "hex digit count set outside hex phase")
    `ASSERT_IMPL(a_acc_only_in_hex, clk, rst_n, acc_reg != 16'h0000,
        phase_reg == jsu_pkg::PH_HEX, "code accumulator set outside hex phase")
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, advance && res_valid,
        !out_valid_reg || m_tready, "result register overwritten while stalled")
    `ASSERT_CLK(a_in_hold, clk, rst_n,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_end_reg), "blocked input item lost or changed")

endmodule

[tb/testbench.sv]
// Self-checking testbench for json_string_unescape_core: random stream traffic
// with random idling on both sides, checked against an in-bench decoder model.
// Depends on jsu_pkg and the core RTL.
module testbench;

    // One raw stream item and one decoded result
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } raw_item_t;

    typedef struct {
        logic [7:0] text;
        logic [2:0] code;
    } dec_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0] s_tuser = 1'b0;    // [0] at_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [2:0] m_tuser;           // [2:0] status
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;  // [7:0] replacement_char

    // Raw bytes waiting to be sent, decoded results waiting to arrive
    raw_item_t   pending[$];
    dec_result_t decoded_q[$];

    // Decoder model state and register copy
    logic [1:0]  dec_phase = jsu_pkg::PH_IDLE;
    logic [1:0]  hex_count = 2'd0;
    logic [15:0] code_acc = 16'h0000;
    logic [7:0]  repl_char = jsu_pkg::REPL_RESET;

    int fail_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    json_string_unescape_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(16, 48);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Value of an ASCII hex digit, -1 if not one
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic add_expected(input logic [7:0] text, input logic [2:0] code);
        dec_result_t r;
        r.text = text;
        r.code = code;
        decoded_q.push_back(r);
    endtask

    // Error: report and fall back to idle
    task automatic drop_string(input logic [2:0] code);
        dec_phase = jsu_pkg::PH_IDLE;
        hex_count = 2'd0;
        code_acc = 16'h0000;
        add_expected(8'h00, code);
    endtask

    // Decoder model: one accepted item, zero or one expected result
    task automatic unescape_step(input logic [7:0] c, input logic eoi);
        int         nib;
        logic [7:0] d;
        logic       known;
        case (dec_phase)
            jsu_pkg::PH_STR:
            begin
                if (eoi)
                    drop_string(jsu_pkg::ST_UNTERM);
                else if (c == jsu_pkg::CH_QUOTE)
                begin
                    dec_phase = jsu_pkg::PH_IDLE;
                    add_expected(8'h00, jsu_pkg::ST_CLOSED);
                end
                else if (c == jsu_pkg::CH_BSL)
                    dec_phase = jsu_pkg::PH_ESC;
                else
                    add_expected(c, jsu_pkg::ST_BYTE);
            end
            jsu_pkg::PH_ESC:
            begin
                if (eoi)
                    drop_string(jsu_pkg::ST_END_ESC);
                else if (c == jsu_pkg::CH_U)
                begin
                    dec_phase = jsu_pkg::PH_HEX;
                    hex_count = 2'd0;
                    code_acc = 16'h0000;
                end
                else
                begin
                    known = 1'b1;
                    d = 8'h00;
                    case (c)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: d = c;
                        jsu_pkg::CH_B: d = jsu_pkg::CTL_BS;
                        jsu_pkg::CH_F: d = jsu_pkg::CTL_FF;
                        jsu_pkg::CH_N: d = jsu_pkg::CTL_LF;
                        jsu_pkg::CH_R: d = jsu_pkg::CTL_CR;
                        jsu_pkg::CH_T: d = jsu_pkg::CTL_TAB;
                        default: known = 1'b0;
                    endcase
                    if (known)
                    begin
                        dec_phase = jsu_pkg::PH_STR;
                        add_expected(d, jsu_pkg::ST_BYTE);
                    end
                    else
                        drop_string(jsu_pkg::ST_BAD_ESC);
                end
            end
            jsu_pkg::PH_HEX:
            begin
                nib = hex_nibble(c);
                if (eoi || nib < 0)
                    drop_string(jsu_pkg::ST_BAD_HEX);
                else
                begin
                    code_acc = {code_acc[11:0], nib[3:0]};
                    if (hex_count != 2'd3)
                        hex_count = hex_count + 2'd1;
                    else
                    begin
                        // codes above ASCII become the replacement byte
                        d = (code_acc <= jsu_pkg::ASCII_MAX) ? code_acc[7:0] : repl_char;
                        dec_phase = jsu_pkg::PH_STR;
                        hex_count = 2'd0;
                        code_acc = 16'h0000;
                        add_expected(d, jsu_pkg::ST_BYTE);
                    end
                end
            end
            default:
            begin
                dec_phase = jsu_pkg::PH_IDLE;
                if (!eoi)
                begin
                    if (c == jsu_pkg::CH_QUOTE)
                        dec_phase = jsu_pkg::PH_STR;
                    else
                        add_expected(8'h00, jsu_pkg::ST_NO_OPEN);
                end
            end
        endcase
    endtask

    // Stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        raw_item_t it;
        it.ch = b;
        it.eoi = 1'b0;
        pending.push_back(it);
    endtask

    task automatic push_end();
        raw_item_t it;
        it.ch = 8'($urandom);
        it.eoi = 1'b1;
        pending.push_back(it);
    endtask

    // Top 'count' nibbles of v as hex digits, letters in random case
    task automatic push_hex_digits(input logic [15:0] v, input int count);
        logic [3:0] n;
        for (int i = 0; i < count; i++)
        begin
            n = v[15 - 4 * i -: 4];
            if (n < 4'd10)
                push_byte("0" + n);
            else if ($urandom_range(0, 1) == 1)
                push_byte("A" + n - 8'd10);
            else
                push_byte("a" + n - 8'd10);
        end
    endtask

    task automatic push_unicode(input logic [15:0] v);
        push_byte(jsu_pkg::CH_BSL);
        push_byte(jsu_pkg::CH_U);
        push_hex_digits(v, 4);
    endtask

    // One string body element: plain byte, short escape or unicode escape
    task automatic add_random_piece();
        logic [7:0] b;
        logic [7:0] short_esc[8];
        short_esc = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                      jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                b = 8'($urandom);
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL)
                    b = 8'($urandom);
                push_byte(b);
            end
            6, 7:
            begin
                push_byte(jsu_pkg::CH_BSL);
                push_byte(short_esc[$urandom_range(0, 7)]);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: push_unicode(16'($urandom_range(0, 16'h007F)));
                    1: push_unicode($urandom_range(0, 1) ? 16'h007F : 16'h0080);
                    2: push_unicode(16'($urandom));
                    default: push_unicode(16'($urandom_range(0, 16'h00FF)));
                endcase
            end
        endcase
    endtask

    // Mostly well-formed strings, some broken ones, some noise between
    task automatic add_random_string();
        logic [7:0] b;
        push_byte(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8))
            add_random_piece();
        case ($urandom_range(0, 15))
            0: push_end();
            1:
            begin
                b = 8'($urandom);
                while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                                 jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                 jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U})
                    b = 8'($urandom);
                push_byte(jsu_pkg::CH_BSL);
                push_byte(b);
            end
            2:
            begin
                push_byte(jsu_pkg::CH_BSL);
                push_end();
            end
            3:
            begin
                push_byte(jsu_pkg::CH_BSL);
                push_byte(jsu_pkg::CH_U);
                push_hex_digits(16'($urandom), $urandom_range(0, 3));
                push_end();
            end
            4:
            begin
                b = 8'($urandom);
                while (hex_nibble(b) >= 0)
                    b = 8'($urandom);
                push_byte(jsu_pkg::CH_BSL);
                push_byte(jsu_pkg::CH_U);
                push_hex_digits(16'($urandom), $urandom_range(0, 3));
                push_byte(b);
            end
            default: push_byte(jsu_pkg::CH_QUOTE);
        endcase
        case ($urandom_range(0, 9))
            0: push_end();
            1: push_byte(8'($urandom));
            default: ;
        endcase
    endtask

    // Register write through the config channel
    task automatic write_repl(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        repl_char = v;
    endtask

    // Wait until everything sent has come back, then let the pipe empty
    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Stream driver
    always @(posedge clk)
    begin : send_proc
        raw_item_t nxt;
        logic      show;
        if (rst_n)
        begin
            show = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                unescape_step(s_tdata, s_tuser[0]);
                show = 1'b0;
            end
            if (!show)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0)
                begin
                    nxt = pending.pop_front();
                    s_tdata <= nxt.ch;
                    s_tuser <= nxt.eoi;
                    show = 1'b1;
                    send_gap = idle_len(send_calm);
                end
            end
            s_tvalid <= show;
        end
    end

    // Result monitor and checker
    always @(posedge clk)
    begin : recv_proc
        dec_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: byte %h code %0d", m_tdata, m_tuser);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.text || m_tuser !== want.code)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: byte exp %h got %h, code exp %0d got %0d",
                                     want.text, m_tdata, want.code, m_tuser);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = idle_len(recv_calm);
            end
        end
    end

    // Run limit
    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Sequence: reset, directed checks, then random phases per register value
    initial
    begin
        logic [7:0] repl_vals[4];
        repl_vals = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'h80};
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // end mark and stray byte while idle
        push_end();
        push_byte(8'h00);
        // extreme plain bytes and the unicode boundary at reset replacement
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_unicode(16'h007F);
        push_unicode(16'h0080);
        push_byte(jsu_pkg::CH_QUOTE);
        // unknown escape
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_BSL);
        push_byte(8'h80);
        // end of input right after a backslash
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_BSL);
        push_end();
        // end of input among hex digits, then a non-hex digit
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_BSL);
        push_byte(jsu_pkg::CH_U);
        push_hex_digits(16'h0000, 1);
        push_end();
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_BSL);
        push_byte(jsu_pkg::CH_U);
        push_byte("g");
        // unterminated string
        push_byte(jsu_pkg::CH_QUOTE);
        push_end();
        wait_drained();

        foreach (repl_vals[p])
        begin
            write_repl(repl_vals[p]);
            while (pending.size() < 100)
                add_random_string();
            wait_drained();
        end

        if (fail_count == 0 && decoded_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
